@@ rtl/tbbe_pkg.sv @@
`timescale 1ns / 1ps

package tbbe_pkg;

  // Width of the degree register.
  localparam int unsigned DEG_BITS = 3;

  // Input item operation codes.
  typedef enum logic [1:0] {
    OP_LOAD_POINT = 2'd0,
    OP_LOAD_ARG   = 2'd1,
    OP_EVAL       = 2'd2
  } op_e;

  // Command broadcast to every cell of the chain.
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_SHIFT,
    CELL_LOAD,
    CELL_MUL,
    CELL_SUM
  } cell_cmd_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_DRAIN,
    ST_MUL,
    ST_SUM,
    ST_ROW_PUT,
    ST_COL_LOAD,
    ST_RESULT
  } state_e;

endpackage

@@ rtl/tbbe_ram.sv @@
`timescale 1ns / 1ps

module tbbe_ram #(
  parameter int unsigned WIDTH = 96,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/tbbe_cell.sv @@
`timescale 1ns / 1ps

module tbbe_cell #(
  parameter int unsigned COORD_BITS = 32,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                        clk_i,
  input  tbbe_pkg::cell_cmd_e         cmd_i,
  input  logic [FRAC_BITS:0]          t_i,
  input  logic [3*COORD_BITS-1:0]     shift_i,
  input  logic [3*COORD_BITS-1:0]     load_i,
  input  logic [3*COORD_BITS-1:0]     nbr_i,
  output logic [3*COORD_BITS-1:0]     point_o
);
  import tbbe_pkg::*;

  localparam int unsigned AW = FRAC_BITS + 2;
  localparam int unsigned PW = COORD_BITS + AW;
  localparam logic [AW-1:0] ONE_Q = AW'(1) << FRAC_BITS;

  logic [3*COORD_BITS-1:0] point_q, point_d;
  logic [COORD_BITS-1:0]   ma_q [3];
  logic [COORD_BITS-1:0]   mb_q [3];
  logic [COORD_BITS-1:0]   ma_d [3];
  logic [COORD_BITS-1:0]   mb_d [3];
  logic signed [AW-1:0]    wa, wb;

  // Weights t and one minus t, both as signed values.
  assign wa = $signed({1'b0, t_i});
  assign wb = $signed(ONE_Q - {1'b0, t_i});

  // Floor-shifted products of own point with t and neighbor with 1-t.
  for (genvar c = 0; c < 3; c++) begin : g_coord
    logic signed [PW-1:0] pa, pb;
    assign pa = $signed(point_q[c*COORD_BITS +: COORD_BITS]) * wa;
    assign pb = $signed(nbr_i[c*COORD_BITS +: COORD_BITS]) * wb;
    assign ma_d[c] = pa[FRAC_BITS +: COORD_BITS];
    assign mb_d[c] = pb[FRAC_BITS +: COORD_BITS];
  end

  // Next point value for each command.
  always_comb begin
    point_d = point_q;
    case (cmd_i)
      CELL_SHIFT: point_d = shift_i;
      CELL_LOAD:  point_d = load_i;
      CELL_SUM: begin
        for (int c = 0; c < 3; c++) begin
          point_d[c*COORD_BITS +: COORD_BITS] = ma_q[c] + mb_q[c];
        end
      end
      default: point_d = point_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    point_q <= point_d;
    if (cmd_i == CELL_MUL) begin
      ma_q <= ma_d;
      mb_q <= mb_d;
    end
  end

  assign point_o = point_q;

endmodule

@@ rtl/tensor_bezier_blossom_eval.sv @@
`timescale 1ns / 1ps

// Channel  | Signals                                      | Direction
// input    | in_valid_i/in_ready_o, opcode, slot, coords, args | into block
// output   | out_valid_o/out_ready_i, point_x/y/z         | out of block
// config   | APB psel/penable/pwrite/paddr/pwdata/prdata  | register file
//
// An evaluate at degree n runs through the row fetches from the point
// memory and a multiply and a sum step per de Casteljau stage in the
// cell chain. Items are taken only while the sequencer is idle; a
// finished point waits in the output register, and loads are still taken.
// Reset clears control state and sets degree to three; stores are undefined.
module tensor_bezier_blossom_eval #(
  parameter int unsigned MAX_DEGREE = 7,
  parameter int unsigned COORD_BITS = 32,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          opcode_i,
  input  logic [$clog2((MAX_DEGREE+1)*(MAX_DEGREE+1))-1:0] slot_i,
  input  logic [COORD_BITS-1:0] coord_x_i,
  input  logic [COORD_BITS-1:0] coord_y_i,
  input  logic [COORD_BITS-1:0] coord_z_i,
  input  logic [FRAC_BITS:0]  arg_first_i,
  input  logic [FRAC_BITS:0]  arg_second_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [COORD_BITS-1:0] point_x_o,
  output logic [COORD_BITS-1:0] point_y_o,
  output logic [COORD_BITS-1:0] point_z_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import tbbe_pkg::*;

  localparam int unsigned NPTS   = MAX_DEGREE + 1;
  localparam int unsigned GDEPTH = NPTS * NPTS;
  localparam int unsigned ABITS  = $clog2(GDEPTH);
  localparam int unsigned CNT    = $clog2(NPTS);
  localparam int unsigned PTW    = 3 * COORD_BITS;

  state_e              state_q, state_d;
  cell_cmd_e           cmd;
  logic [DEG_BITS-1:0] degree_q;
  logic [CNT-1:0]      n_w;
  logic [ABITS-1:0]    addr_q;
  logic [CNT-1:0]      col_q, row_cnt_q, stage_q;
  logic                pass_q, rd_vld_q;
  logic [FRAC_BITS:0]  args_first_q  [MAX_DEGREE];
  logic [FRAC_BITS:0]  args_second_q [MAX_DEGREE];
  logic [FRAC_BITS:0]  t_w;
  logic [PTW-1:0]      rdata;
  logic [PTW-1:0]      cell_pt [NPTS];
  logic [PTW-1:0]      rowpt_q [NPTS];
  logic                out_valid_q;
  logic [PTW-1:0]      out_q;
  logic                in_acc, grid_we;
  op_e                 op;

  // Configuration port: degree at index zero; only paddr[2] is decoded, so indexes zero to three all reach it.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? 32'(degree_q) : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      degree_q <= DEG_BITS'(3);
    end else if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
      degree_q <= pwdata[DEG_BITS-1:0];
    end
  end

  // Effective degree, saturated to the largest supported one.
  assign n_w = (32'(degree_q) > MAX_DEGREE) ? CNT'(MAX_DEGREE) : CNT'(degree_q);

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign op         = op_e'(opcode_i);
  assign grid_we    = in_acc && (op == OP_LOAD_POINT) && (32'(slot_i) < GDEPTH);

  // Control point memory.
  tbbe_ram #(
    .WIDTH(PTW),
    .DEPTH(GDEPTH)
  ) u_grid (
    .clk_i  (clk_i),
    .we_i   (grid_we),
    .waddr_i(slot_i),
    .wdata_i({coord_z_i, coord_y_i, coord_x_i}),
    .raddr_i(addr_q),
    .rdata_o(rdata)
  );

  // Argument registers.
  always_ff @(posedge clk_i) begin
    if (in_acc && (op == OP_LOAD_ARG) && (32'(slot_i) < MAX_DEGREE)) begin
      args_first_q[slot_i[CNT-1:0]]  <= arg_first_i;
      args_second_q[slot_i[CNT-1:0]] <= arg_second_i;
    end
  end

  // Argument for the current stage.
  always_comb begin
    t_w = '0;
    if (stage_q != '0) begin
      t_w = pass_q ? args_first_q[stage_q - CNT'(1)] : args_second_q[stage_q - CNT'(1)];
    end
  end

  // The cell chain; fetched points enter at cell n and move toward cell zero.
  for (genvar j = 0; j < NPTS; j++) begin : g_cell
    logic [PTW-1:0] sh, nb;
    if (j == NPTS - 1) begin : g_last
      assign sh = rdata;
      assign nb = cell_pt[j];
    end else begin : g_mid
      assign sh = (CNT'(j) == n_w) ? rdata : cell_pt[j+1];
      assign nb = cell_pt[j+1];
    end
    tbbe_cell #(
      .COORD_BITS(COORD_BITS),
      .FRAC_BITS (FRAC_BITS)
    ) u_cell (
      .clk_i  (clk_i),
      .cmd_i  (cmd),
      .t_i    (t_w),
      .shift_i(sh),
      .load_i (rowpt_q[j]),
      .nbr_i  (nb),
      .point_o(cell_pt[j])
    );
  end

  // Row results collect in a shift line, entering at position n.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_ROW_PUT) begin
      for (int j = 0; j < NPTS; j++) begin
        if ((j == NPTS - 1) || (CNT'(j) == n_w)) begin
          rowpt_q[j] <= cell_pt[0];
        end else begin
          rowpt_q[j] <= rowpt_q[j+1];
        end
      end
    end
  end

  // Next state and cell command.
  always_comb begin
    state_d = state_q;
    cmd     = rd_vld_q ? CELL_SHIFT : CELL_HOLD;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && (op == OP_EVAL)) state_d = ST_FETCH;
      end
      ST_FETCH: begin
        if (col_q == n_w) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_d = (n_w == '0) ? ST_ROW_PUT : ST_MUL;
      end
      ST_MUL: begin
        cmd     = CELL_MUL;
        state_d = ST_SUM;
      end
      ST_SUM: begin
        cmd = CELL_SUM;
        if (stage_q == CNT'(1)) begin
          state_d = pass_q ? ST_RESULT : ST_ROW_PUT;
        end else begin
          state_d = ST_MUL;
        end
      end
      ST_ROW_PUT: begin
        state_d = (row_cnt_q == n_w) ? ST_COL_LOAD : ST_FETCH;
      end
      ST_COL_LOAD: begin
        cmd     = CELL_LOAD;
        state_d = (n_w == '0) ? ST_RESULT : ST_MUL;
      end
      ST_RESULT: begin
        if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Sequencer counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q    <= '0;
      col_q     <= '0;
      row_cnt_q <= '0;
      stage_q   <= '0;
      pass_q    <= 1'b0;
      rd_vld_q  <= 1'b0;
    end else begin
      rd_vld_q <= (state_q == ST_FETCH);
      case (state_q)
        ST_IDLE: begin
          addr_q    <= '0;
          col_q     <= '0;
          row_cnt_q <= '0;
          pass_q    <= 1'b0;
          stage_q   <= n_w;
        end
        ST_FETCH: begin
          addr_q <= addr_q + ABITS'(1);
          col_q  <= col_q + CNT'(1);
        end
        ST_SUM: begin
          stage_q <= stage_q - CNT'(1);
        end
        ST_ROW_PUT: begin
          col_q     <= '0;
          row_cnt_q <= row_cnt_q + CNT'(1);
          stage_q   <= n_w;
        end
        ST_COL_LOAD: begin
          pass_q  <= 1'b1;
          stage_q <= n_w;
        end
        default: begin
        end
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == ST_RESULT) && (!out_valid_q || out_ready_i)) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_RESULT) && (!out_valid_q || out_ready_i)) begin
      out_q <= cell_pt[0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign point_x_o   = out_q[0 +: COORD_BITS];
  assign point_y_o   = out_q[COORD_BITS +: COORD_BITS];
  assign point_z_o   = out_q[2*COORD_BITS +: COORD_BITS];

endmodule
